@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ledm_pkg.sv @@
// Shared types, constants and pixel functions of the LED matrix animation generator.
// No dependencies; imported by ledm_ctrl, ledm_rowgen and the top level.
package ledm_pkg;

    localparam int MATRIX_SIZE = 16;
    localparam int ROW_W       = 4;
    localparam int PIX_W       = 2;
    localparam int ROW_BITS    = MATRIX_SIZE * PIX_W;
    localparam int TICK_W      = 17;
    localparam int ELAPSED_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;

    localparam logic [TICK_W-1:0] TICK_MAX = 17'h1FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_FRAMES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_FRAMES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRAMES = 3'd6;

    // Pixel codes
    localparam logic [PIX_W-1:0] PIX_EMPTY = 2'd0;
    localparam logic [PIX_W-1:0] PIX_WALL  = 2'd1;
    localparam logic [PIX_W-1:0] PIX_BALL  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WIN  = 2'd0,
        KIND_DISC = 2'd1,
        KIND_STOP = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // One frame job: everything the row generator needs, worked out at accept.
    typedef struct packed {
        logic       draw;    // 16 rows follow; else one status result
        logic       done;    // done flag after the step
        t_kind      kind;
        logic [7:0] rsq;     // win ball radius squared, saturated above the matrix
        logic [1:0] fr_lo;   // low bits of the frame count
        logic [3:0] sq_lo;   // square bounds, inclusive
        logic [3:0] sq_hi;
    } t_job;

    // f mod 17 for an 8-bit f: reciprocal multiply and one correction step.
    function automatic logic [4:0] mod17(input logic [7:0] f);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  rem;
        prod = 16'(f) * 16'd241;
        q    = prod[15:12];
        rem  = f - 8'(q * 8'd17);
        if (rem >= 8'd17) begin
            rem = rem - 8'd17;
        end
        return rem[4:0];
    endfunction

    // Distance of a coordinate from the matrix center.
    function automatic logic [3:0] center_dist(input logic [3:0] c);
        return c[3] ? {1'b0, c[2:0]} : 4'd8 - c;
    endfunction

    function automatic logic [ROW_BITS-1:0] row_pixels(input t_job job, input logic [3:0] y);
        logic [ROW_BITS-1:0] row;
        logic [3:0]          x;
        logic [3:0]          ax;
        logic [3:0]          ay;
        logic [7:0]          d2;
        logic [PIX_W-1:0]    code;
        row = '0;
        ay  = center_dist(y);
        for (int i = 0; i < MATRIX_SIZE; i++) begin
            x    = 4'(i);
            ax   = center_dist(x);
            d2   = 8'(ax * ax) + 8'(ay * ay);
            code = PIX_EMPTY;
            case (job.kind)
                KIND_WIN: begin
                    code = (d2 <= job.rsq) ? PIX_BALL : PIX_EMPTY;
                end
                KIND_DISC: begin
                    if (x == 4'd8 && y == 4'd8 && !job.fr_lo[1]) begin
                        code = PIX_BALL;
                    end else begin
                        code = (x[0] ^ y[0] ^ job.fr_lo[0]) ? PIX_EMPTY : PIX_WALL;
                    end
                end
                KIND_STOP: begin
                    code = (x >= job.sq_lo && x <= job.sq_hi &&
                            y >= job.sq_lo && y <= job.sq_hi) ? PIX_WALL : PIX_EMPTY;
                end
                default: begin
                    code = PIX_EMPTY;
                end
            endcase
            row[i*PIX_W +: PIX_W] = code;
        end
        return row;
    endfunction

endpackage

@@ hw/rtl/ledm_ctrl.sv @@
// Configuration registers, tick accumulator and frame/cycle counters; builds frame jobs.
// Depends on ledm_pkg.
module ledm_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ledm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ledm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ledm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_job_ready,
    output logic                             o_job_valid,
    output ledm_pkg::t_job                   o_job
);
    import ledm_pkg::*;

    t_kind               r_kind;
    logic [15:0]         r_period;
    logic [7:0]          r_cycles;
    logic [3:0]          r_max_radius;
    logic [7:0]          r_win_frames;
    logic [7:0]          r_disc_frames;
    logic [7:0]          r_stop_frames;

    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [7:0]          r_frame, n_frame;
    logic [7:0]          r_cycle, n_cycle;
    logic                r_done, n_done;

    logic                accept;
    logic                cfg_we;
    logic [TICK_W:0]     sum;
    logic [TICK_W-1:0]   sat;
    logic                due;
    logic                finished;
    logic [7:0]          frame_inc;
    logic [7:0]          limit;
    logic [7:0]          radius;
    logic [4:0]          rem;
    logic [4:0]          side;
    logic [3:0]          half;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_s_tready  = i_job_ready;
    assign o_job_valid = i_s_tvalid;
    assign accept      = i_s_tvalid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= KIND_WIN;
            r_period      <= 16'd200;
            r_cycles      <= 8'd3;
            r_max_radius  <= 4'd8;
            r_win_frames  <= 8'd17;
            r_disc_frames <= 8'd8;
            r_stop_frames <= 8'd17;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_KIND:        r_kind        <= t_kind'(i_cfg_data[1:0]);
                CFG_PERIOD:      r_period      <= i_cfg_data;
                CFG_CYCLES:      r_cycles      <= i_cfg_data[7:0];
                CFG_MAX_RADIUS:  r_max_radius  <= i_cfg_data[3:0];
                CFG_WIN_FRAMES:  r_win_frames  <= i_cfg_data[7:0];
                CFG_DISC_FRAMES: r_disc_frames <= i_cfg_data[7:0];
                CFG_STOP_FRAMES: r_stop_frames <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Frame geometry from the current frame count
    always_comb begin
        if (r_frame <= {4'd0, r_max_radius}) begin
            radius = {4'd0, r_max_radius} - r_frame;
        end else begin
            radius = r_frame - {4'd0, r_max_radius};
        end
        rem  = mod17(r_frame);
        side = 5'd16 - rem;
        half = side[4:1];
    end

    always_comb begin
        case (r_kind)
            KIND_WIN:  limit = r_win_frames;
            KIND_DISC: limit = r_disc_frames;
            default:   limit = r_stop_frames;
        endcase
    end

    assign sum       = (TICK_W+1)'(r_tick) + (TICK_W+1)'(i_s_tdata[ELAPSED_W-1:0]);
    assign sat       = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
    assign due       = sat >= {1'b0, r_period};
    assign finished  = r_cycle == r_cycles;
    assign frame_inc = r_frame + 8'd1;

    always_comb begin
        o_job.draw  = due && !finished && (r_kind != KIND_NONE);
        o_job.done  = r_done || (due && finished);
        o_job.kind  = r_kind;
        o_job.rsq   = (radius >= 8'd12) ? 8'd144 : 8'(radius[3:0] * radius[3:0]);
        o_job.fr_lo = r_frame[1:0];
        o_job.sq_lo = 4'd8 - half;
        o_job.sq_hi = 4'd7 + half + {3'd0, side[0]};
    end

    always_comb begin
        n_tick  = r_tick;
        n_frame = r_frame;
        n_cycle = r_cycle;
        n_done  = r_done;
        if (cfg_we && i_cfg_index == CFG_KIND) begin
            n_tick  = '0;
            n_frame = '0;
            n_cycle = '0;
            n_done  = 1'b0;
        end else if (accept) begin
            if (!due) begin
                n_tick = sat;
            end else if (finished) begin
                n_tick = sat;
                n_done = 1'b1;
            end else begin
                n_tick = '0;
                if (r_kind != KIND_NONE) begin
                    if (frame_inc == limit) begin
                        n_frame = '0;
                        n_cycle = r_cycle + 8'd1;
                    end else begin
                        n_frame = frame_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_frame <= '0;
            r_cycle <= '0;
            r_done  <= 1'b0;
        end else begin
            r_tick  <= n_tick;
            r_frame <= n_frame;
            r_cycle <= n_cycle;
            r_done  <= n_done;
        end
    end

endmodule

@@ hw/rtl/ledm_rowgen.sv @@
// Job register, row counter, row pixel logic and output register.
// Depends on ledm_pkg.
module ledm_rowgen (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    output logic                             o_job_ready,
    input  ledm_pkg::t_job                   i_job,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ledm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tlast,
    output logic                             o_m_tuser
);
    import ledm_pkg::*;

    logic                r_busy;
    t_job                r_job;
    logic [ROW_W-1:0]    r_y;

    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_row;
    logic [ROW_BITS-1:0] r_out_pix;
    logic                r_out_last;
    logic                r_out_done;
    logic                r_out_drawn;

    logic                load_out;
    logic                last;
    logic                take_job;

    assign load_out    = r_busy && (!r_out_valid || i_m_tready);
    assign last        = !r_job.draw || (r_y == ROW_W'(MATRIX_SIZE - 1));
    assign o_job_ready = !r_busy || (load_out && last);
    assign take_job    = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take_job) begin
            r_busy <= 1'b1;
        end else if (load_out && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_job <= i_job;
            r_y   <= '0;
        end else if (load_out) begin
            r_y   <= r_y + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status results carry zero row and pixels
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_drawn <= r_job.draw;
            r_out_row   <= r_job.draw ? r_y : '0;
            r_out_pix   <= r_job.draw ? row_pixels(r_job, r_y) : '0;
            r_out_last  <= last;
            r_out_done  <= r_job.done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out_done, r_out_pix, r_out_row};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_drawn;

endmodule

@@ hw/rtl/led_matrix_animation_generator.sv @@
// Top level of the LED matrix animation generator.
// Depends on ledm_pkg, ledm_ctrl and ledm_rowgen.
//
// Usage:
//   Slave stream: one transfer per tick update, tdata[15:0] = elapsed_ms.
//   Configuration channel: i_cfg_index selects register 0..6 (kind, frame
//   period, cycles to run, max radius, win/disconnected/stopped frames),
//   i_cfg_data carries the value; always ready, index 7 is ignored. Writing
//   the kind restarts the sequence. Write only while the block is idle.
//   Master stream: an update yields one status transfer (tuser 0, tlast 1)
//   or, when a frame is due, cycles remain and the kind is not none, sixteen
//   row transfers (tuser 1, row 0 to 15, tlast on row 15). done_res: tdata[36].
// Order and throughput:
//   The job register loads on the slave transfer, the output register after it.
//   While the master is ready, status-only updates are taken one per cycle
//   and a drawn frame holds the row generator for its sixteen rows, one row per
//   cycle; the next update is taken as the last row is registered.
// Reset and stall:
//   Synchronous active-low reset clears counters, accumulator, done flag and
//   all valid state and loads register defaults. When the master side stalls,
//   the output register holds its transfer and the row counter waits; the
//   slave side is held off while a job in flight is not on its last result.
module led_matrix_animation_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave stream, tdata: [15:0] elapsed_ms
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ledm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ledm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ledm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: [3:0] row_index, [35:4] row_pixels, [36] done_res, [39:37] zero
    output logic [ledm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tlast,  // last_row
    output logic                             o_m_tuser   // tuser: [0] frame_drawn
);
    import ledm_pkg::*;

    t_job job;
    logic job_valid;
    logic job_ready;

    // Accumulate ticks, advance counters and build the frame job
    ledm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job_ready (job_ready),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Hold the job and emit its rows or status result
    ledm_rowgen u_rowgen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

@@ hw/rtl/ledm_checker.sv @@
// Port-level checker for the LED matrix animation generator, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ledm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")
    `CHK_ASSERT(a_status_form, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tlast && (o_m_tdata[35:0] == 36'd0), "status result not last or not empty")
    `CHK_ASSERT(a_row_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> (o_m_tlast == (o_m_tdata[3:0] == 4'hF)), "tlast not on row fifteen")
    `CHK_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind led_matrix_animation_generator ledm_checker u_ledm_checker (.*);
